// File: design/battery_voltage_averager_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery voltage averager
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_AVERAGER_TOP_ASSERT_SVH
`define BATTERY_VOLTAGE_AVERAGER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BVA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/bva_pkg.sv
// ----------------------------------------------------------------------------
// bva_pkg
// Types and constants shared by the battery voltage averager modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bva_pkg;

	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned MV_W      = 17;
	localparam int unsigned PROD_W    = 25;
	localparam int unsigned SCALED_W  = 13;
	localparam int unsigned RAW_W     = 15;
	localparam int unsigned DIV_STEPS = 25;
	localparam int unsigned DIV_CNT_W = 5;

	localparam logic [SCALED_W-1:0] VBAT_SCALE = 13'd6600;
	localparam logic [RAW_W-1:0]    RAW_MAX    = 15'h7FFF;

	localparam logic [SAMPLE_W-1:0] REF_CAL_RST = 12'd1530;
	localparam logic [SAMPLE_W-1:0] OFFSET_RST  = 12'd0;
	localparam logic [SAMPLE_W-1:0] MIN_MV_RST  = 12'd100;

	localparam logic [CFG_IDX_W-1:0] REG_REF_CAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MV  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic mul1;
		logic mul2;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

`default_nettype wire

// File: design/bva_ctrl.sv
// ----------------------------------------------------------------------------
// bva_ctrl
// Sequencer: sample intake, scale, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bva_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire              out_stall,
	input  bva_pkg::status_t status,
	output bva_pkg::cmd_t    cmd
);

	bva_pkg::state_t state_q, state_d;
	logic [bva_pkg::DIV_CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic div_last;
	logic out_free;

	assign div_last = cnt_q == bva_pkg::DIV_CNT_W'(bva_pkg::DIV_STEPS - 1);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			bva_pkg::ST_IDLE: begin
				if (in_valid && status.last)
					state_d = bva_pkg::ST_MUL1;
			end
			bva_pkg::ST_MUL1: state_d = bva_pkg::ST_MUL2;
			bva_pkg::ST_MUL2: state_d = bva_pkg::ST_DIV;
			bva_pkg::ST_DIV: begin
				if (div_last)
					state_d = bva_pkg::ST_DONE;
			end
			bva_pkg::ST_DONE: begin
				if (out_free)
					state_d = bva_pkg::ST_IDLE;
			end
			default: state_d = bva_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			bva_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			bva_pkg::ST_MUL1: cmd.mul1     = 1'b1;
			bva_pkg::ST_MUL2: cmd.mul2     = 1'b1;
			bva_pkg::ST_DIV:  cmd.div_step = 1'b1;
			bva_pkg::ST_DONE: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bva_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.mul2)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			// hold the result until the transaction completes
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: design/bva_datapath.sv
// ----------------------------------------------------------------------------
// bva_datapath
// Channel sums, averaging, scaling, shift-subtract divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bva_datapath #(
	parameter int unsigned AVG_SHIFT = 3
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  bva_pkg::cmd_t                         cmd,
	output bva_pkg::status_t                      status,
	input  wire                                   cfg_we,
	input  wire [bva_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [bva_pkg::SAMPLE_W-1:0]           cfg_data,
	input  wire [bva_pkg::SAMPLE_W-1:0]           sample,
	input  wire                                   restart,
	output logic signed [bva_pkg::MV_W-1:0]       battery_mv,
	output logic                                  battery_absent
);

	localparam int unsigned SUM_W   = bva_pkg::SAMPLE_W + AVG_SHIFT;
	localparam int unsigned SEQ_LEN = 2 << AVG_SHIFT;
	localparam int unsigned POS_W   = AVG_SHIFT + 1;
	localparam int unsigned SW      = bva_pkg::SAMPLE_W;
	localparam int unsigned PW      = bva_pkg::PROD_W;

	logic [SW-1:0] ref_cal_q, offset_q, min_mv_q;

	logic [POS_W-1:0] pos_q, pos_eff;
	logic [SUM_W-1:0] sum0_q, sum1_q, sum0_d, sum1_d;
	logic             last;

	logic [SW-1:0] vbat_q, vref_q;
	logic          vref_zero_q;

	logic [PW-1:0]                    scale_prod, cal_prod;
	logic [bva_pkg::SCALED_W-1:0]     scaled_q;
	logic [PW-1:0]                    num_q;
	logic [SW-1:0]                    rem_q;
	logic [SW:0]                      shifted, diff;
	logic                             fits;

	logic [bva_pkg::RAW_W-1:0]        raw;
	logic                             absent;
	logic [bva_pkg::MV_W-1:0]         res;
	logic [bva_pkg::MV_W-1:0]         battery_mv_q;
	logic                             battery_absent_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_cal_q <= bva_pkg::REF_CAL_RST;
			offset_q  <= bva_pkg::OFFSET_RST;
			min_mv_q  <= bva_pkg::MIN_MV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bva_pkg::REG_REF_CAL: ref_cal_q <= cfg_data;
				bva_pkg::REG_OFFSET:  offset_q  <= cfg_data;
				bva_pkg::REG_MIN_MV:  min_mv_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// accumulate: even position is the battery channel, odd the reference
	always_comb begin
		pos_eff = restart ? '0 : pos_q;
		sum0_d  = restart ? '0 : sum0_q;
		sum1_d  = restart ? '0 : sum1_q;
		if (pos_eff[0])
			sum1_d = sum1_d + SUM_W'(sample);
		else
			sum0_d = sum0_d + SUM_W'(sample);
		last = pos_eff == POS_W'(SEQ_LEN - 1);
	end

	assign status.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			sum0_q <= '0;
			sum1_q <= '0;
		end else if (cmd.accept) begin
			if (last) begin
				pos_q  <= '0;
				sum0_q <= '0;
				sum1_q <= '0;
			end else begin
				pos_q  <= pos_eff + 1'b1;
				sum0_q <= sum0_d;
				sum1_q <= sum1_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && last) begin
			vbat_q      <= SW'(sum0_d >> AVG_SHIFT);
			vref_q      <= SW'(sum1_d >> AVG_SHIFT);
			vref_zero_q <= (sum1_d >> AVG_SHIFT) == '0;
		end
	end

	assign scale_prod = PW'(bva_pkg::VBAT_SCALE) * PW'(vbat_q);
	assign cal_prod   = PW'(scaled_q) * PW'(ref_cal_q);

	// restoring divide, one quotient bit per step, quotient shifts into num_q
	assign shifted = {rem_q, num_q[PW-1]};
	assign diff    = shifted - {1'b0, vref_q};
	assign fits    = shifted >= {1'b0, vref_q};

	always_ff @(posedge clk) begin
		if (cmd.mul1)
			scaled_q <= bva_pkg::SCALED_W'(scale_prod >> 12);
		if (cmd.mul2) begin
			num_q <= cal_prod;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[PW-2:0], fits};
			rem_q <= fits ? diff[SW-1:0] : shifted[SW-1:0];
		end
	end

	always_comb begin
		raw    = (|num_q[PW-1:bva_pkg::RAW_W]) ? bva_pkg::RAW_MAX : num_q[bva_pkg::RAW_W-1:0];
		absent = vref_zero_q || (raw < bva_pkg::RAW_W'(min_mv_q));
		res    = bva_pkg::MV_W'(raw)
			+ {{(bva_pkg::MV_W - SW){offset_q[SW-1]}}, offset_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			battery_mv_q     <= absent ? '1 : res;
			battery_absent_q <= absent;
		end
	end

	assign battery_mv     = signed'(battery_mv_q);
	assign battery_absent = battery_absent_q;

endmodule

`default_nettype wire

// File: design/battery_voltage_averager_top.sv
// ----------------------------------------------------------------------------
// battery_voltage_averager_top
// Oversampled ratiometric battery voltage measurement.
// ----------------------------------------------------------------------------
// Samples arrive alternately battery divider, internal reference, for
// 2^AVG_SHIFT rounds; each is taken while in_stall is low. The last one of
// a measurement starts the computation (states ST_MUL1 and ST_MUL2, the
// bit-serial divider for DIV_STEPS steps, the load of the result register),
// during which in_stall is high; it stays high longer only if the previous
// result has not yet been taken. One result per measurement: battery_mv is
// -1 with battery_absent set when the reference average is zero or the
// saturated reading falls below min_mv, else the reading plus the signed
// offset. A restart on a sample clears both sums and the position first.
`default_nettype none

module battery_voltage_averager_top #(
	parameter int unsigned AVG_SHIFT = 3
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire [bva_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire [bva_pkg::SAMPLE_W-1:0]           cfg_data,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire [bva_pkg::SAMPLE_W-1:0]           sample,
	input  wire                                   restart,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [bva_pkg::MV_W-1:0]       battery_mv,
	output logic                                  battery_absent
);

	bva_pkg::cmd_t    cmd;
	bva_pkg::status_t status;

	bva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bva_datapath #(
		.AVG_SHIFT (AVG_SHIFT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample         (sample),
		.restart        (restart),
		.battery_mv     (battery_mv),
		.battery_absent (battery_absent)
	);

endmodule

`default_nettype wire

// File: design/bva_checker.sv
// ----------------------------------------------------------------------------
// bva_checker
// Port-level checks for the battery voltage averager, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_voltage_averager_top_assert.svh"

module bva_checker (
	input wire                                    clk,
	input wire                                    arst_n,
	input wire                                    in_stall,
	input wire                                    out_valid,
	input wire                                    out_stall,
	input wire signed [bva_pkg::MV_W-1:0]         battery_mv,
	input wire                                    battery_absent
);

	`BVA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`BVA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(battery_mv) && $stable(battery_absent), "stalled result changed")
	`BVA_ASSERT_SAME(a_absent_code, clk, arst_n, out_valid && battery_absent, battery_mv == -17'sd1, "absent battery without -1")
	`BVA_ASSERT_SAME(a_result_after_busy, clk, arst_n, $rose(out_valid), $past(in_stall), "result appeared without computation")

endmodule

bind battery_voltage_averager_top bva_checker u_bva_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.battery_mv     (battery_mv),
	.battery_absent (battery_absent)
);

`default_nettype wire
